/* src/vslc_pkg.sv */
// ----------------------------------------------------------------------------
// Variable-slot LRU object cache package
// Shared types, codes and constants for the object cache and its submodules.
// ----------------------------------------------------------------------------
package vslc_pkg;

    // Default number of slots in the cache.
    localparam int VSLC_SLOTS = 16;

    // Field widths.
    localparam int FUNC_W  = 2;
    localparam int ADDR_W  = 32;
    localparam int BYTES_W = 19;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int USE_W   = 32;

    // Addresses below this limit bypass the cache.
    localparam logic [ADDR_W-1:0] PASS_LIMIT = 32'd262144;
    // Only slots whose last use lies below this value may be replaced.
    localparam logic [USE_W-1:0] LRU_CEILING = 32'h7fffffff;
    // Store size after reset.
    localparam logic [BYTES_W-1:0] STORE_RESET = 19'd65536;

    // Operation codes.
    localparam logic [FUNC_W-1:0] FN_LOOKUP    = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FLUSH_ONE = 2'd1;
    localparam logic [FUNC_W-1:0] FN_FLUSH_ALL = 2'd2;
    localparam logic [FUNC_W-1:0] FN_UNUSED    = 2'd3;

    // Result status codes.
    localparam logic [STAT_W-1:0] ST_PASS         = 3'd0;
    localparam logic [STAT_W-1:0] ST_HIT          = 3'd1;
    localparam logic [STAT_W-1:0] ST_REUSED       = 3'd2;
    localparam logic [STAT_W-1:0] ST_APPENDED     = 3'd3;
    localparam logic [STAT_W-1:0] ST_REPLACED     = 3'd4;
    localparam logic [STAT_W-1:0] ST_FLUSH_APPEND = 3'd5;
    localparam logic [STAT_W-1:0] ST_TOO_LARGE    = 3'd6;
    localparam logic [STAT_W-1:0] ST_FLUSH_DONE   = 3'd7;

    // Configuration register word index.
    localparam logic REG_STORE_BYTES = 1'b0;

    // Input item.
    typedef struct packed {
        logic [FUNC_W-1:0]  func;
        logic [ADDR_W-1:0]  remote_addr;
        logic [BYTES_W-1:0] item_bytes;
    } req_item_t;

    // Result item.
    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] local_addr;
    } rsp_item_t;

    // One slot as held in the slot memory.
    typedef struct packed {
        logic [ADDR_W-1:0]  tag;
        logic [BYTES_W-1:0] bucket;
        logic [BYTES_W-1:0] base;
        logic [USE_W-1:0]   last_use;
    } slot_entry_t;

    // Flags from the shared slot compare unit.
    typedef struct packed {
        logic tag_hit;
        logic is_empty;
        logic fits;
        logic older;
    } cmp_result_t;

endpackage

/* src/vslc_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module vslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [0:DEPTH-1];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* src/vslc_cmp.sv */
// ----------------------------------------------------------------------------
// Slot compare unit
// Compares one slot read from memory against the item being worked on.
// ----------------------------------------------------------------------------
module vslc_cmp
    import vslc_pkg::*;
(
    input  slot_entry_t        entry,
    input  logic [ADDR_W-1:0]  key_addr,
    input  logic [BYTES_W-1:0] key_bytes,
    input  logic [USE_W-1:0]   best_use,
    output cmp_result_t        res
);

    // Tag match, empty slot, bucket fit and age against the best so far.
    always_comb
    begin
        res.tag_hit  = (entry.tag == key_addr);
        res.is_empty = (entry.tag == '0);
        res.fits     = (entry.bucket >= key_bytes);
        res.older    = (entry.last_use < best_use);
    end

endmodule

/* src/variable_slot_lru_object_cache.sv */
// ----------------------------------------------------------------------------
// Variable-slot LRU object cache
// Maps remote object addresses to slots of a local store, scanning the slot
// memory one slot at a time through a shared compare unit.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  req      in         req_valid/req_stall   req (func, remote_addr, item_bytes)
//  rsp      out        rsp_valid/rsp_stall   rsp (status, slot, local_addr)
//  cfg      in         APB write/read        store_bytes at word 0
//
// A lookup miss scans every allocated slot and then decides a placement; a flush-one
// scans every allocated slot. Each slot passes through a memory read state and a
// compare state. A hit ends the scan at the slot that hits.
// Passthrough, flush-all and the unused code skip the scan.
// Reset clears the slot count, the use clock and all control state, and sets
// store_bytes to 65536; slot memory is never read above the slot count.
// A new item is taken while the previous result still waits on rsp_stall.
// ----------------------------------------------------------------------------
module variable_slot_lru_object_cache
    import vslc_pkg::*;
#(
    parameter int SLOTS = VSLC_SLOTS
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_item_t   req,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output rsp_item_t   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOT_COUNT = CNT_W'(SLOTS);

    localparam int STATE_W = 3;
    localparam logic [STATE_W-1:0] S_IDLE   = 3'd0;
    localparam logic [STATE_W-1:0] S_READ   = 3'd1;
    localparam logic [STATE_W-1:0] S_CHECK  = 3'd2;
    localparam logic [STATE_W-1:0] S_DECIDE = 3'd3;
    localparam logic [STATE_W-1:0] S_OUT    = 3'd4;

    logic [STATE_W-1:0] state_reg;
    logic [STATE_W-1:0] state_next;

    logic [BYTES_W-1:0] store_bytes_reg;
    logic [CNT_W-1:0]   slots_reg;
    logic [BYTES_W-1:0] end_used_reg;
    logic [USE_W-1:0]   use_clock_reg;
    logic [IDX_W-1:0]   idx_reg;

    logic [ADDR_W-1:0]  addr_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic               flush_reg;

    logic               empty_found_reg;
    logic [IDX_W-1:0]   empty_idx_reg;
    logic [BYTES_W-1:0] empty_bucket_reg;
    logic [BYTES_W-1:0] empty_base_reg;

    logic               best_found_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    logic [USE_W-1:0]   best_use_reg;
    logic [BYTES_W-1:0] best_bucket_reg;
    logic [BYTES_W-1:0] best_base_reg;

    rsp_item_t          res_reg;
    rsp_item_t          rsp_reg;
    logic               rsp_valid_reg;

    logic               req_take;
    logic               rsp_free;
    logic               cfg_write;
    logic               last_slot;

    slot_entry_t        rd_entry;
    slot_entry_t        wr_entry;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    cmp_result_t        cmp;

    logic [BYTES_W:0]   space_diff;
    logic [BYTES_W-1:0] space;
    logic               too_large;
    logic               append_fit;

    // Slot memory and the shared compare unit.
    vslc_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (wr_entry),
        .raddr (idx_reg),
        .rdata (rd_entry)
    );

    vslc_cmp u_cmp (
        .entry     (rd_entry),
        .key_addr  (addr_reg),
        .key_bytes (bytes_reg),
        .best_use  (best_use_reg),
        .res       (cmp)
    );

    // Handshakes.
    assign req_stall = (state_reg != S_IDLE);
    assign req_take  = req_valid && (state_reg == S_IDLE);
    assign rsp_free  = !rsp_valid_reg || !rsp_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_STORE_BYTES);
    assign prdata    = (paddr[2] == REG_STORE_BYTES) ? {13'd0, store_bytes_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            store_bytes_reg <= STORE_RESET;
        end
        else if (cfg_write)
        begin
            store_bytes_reg <= pwdata[BYTES_W-1:0];
        end
    end

    // Miss placement checks against the free tail of the store.
    assign space_diff = {1'b0, store_bytes_reg} - {1'b0, end_used_reg};
    assign space      = space_diff[BYTES_W] ? '0 : space_diff[BYTES_W-1:0];
    assign too_large  = (bytes_reg > store_bytes_reg);
    assign append_fit = (slots_reg < SLOT_COUNT) && (bytes_reg <= space);
    assign last_slot  = ((CNT_W'(idx_reg) + CNT_W'(1)) == slots_reg);

    // Slot memory write: hit and flush updates while scanning, placement on a miss.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg;
        wr_entry  = rd_entry;
        if (state_reg == S_CHECK)
        begin
            if (cmp.tag_hit)
            begin
                ram_we = 1'b1;
                if (flush_reg)
                begin
                    wr_entry.tag      = '0;
                    wr_entry.last_use = '0;
                end
                else
                begin
                    wr_entry.last_use = use_clock_reg;
                end
            end
        end
        else if ((state_reg == S_DECIDE) && !too_large)
        begin
            ram_we            = 1'b1;
            wr_entry.tag      = addr_reg;
            wr_entry.last_use = use_clock_reg;
            if (empty_found_reg)
            begin
                ram_waddr       = empty_idx_reg;
                wr_entry.bucket = empty_bucket_reg;
                wr_entry.base   = empty_base_reg;
            end
            else if (append_fit)
            begin
                ram_waddr       = slots_reg[IDX_W-1:0];
                wr_entry.bucket = bytes_reg;
                wr_entry.base   = end_used_reg;
            end
            else if (best_found_reg)
            begin
                ram_waddr       = best_idx_reg;
                wr_entry.bucket = best_bucket_reg;
                wr_entry.base   = best_base_reg;
            end
            else
            begin
                ram_waddr         = '0;
                wr_entry.bucket   = bytes_reg;
                wr_entry.base     = '0;
                wr_entry.last_use = '0;
            end
        end
    end

    // Sequencer state transitions.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_take)
                begin
                    if (((req.func == FN_LOOKUP) && (req.remote_addr >= PASS_LIMIT))
                        || (req.func == FN_FLUSH_ONE))
                    begin
                        if (slots_reg == '0)
                        begin
                            state_next = (req.func == FN_LOOKUP) ? S_DECIDE : S_OUT;
                        end
                        else
                        begin
                            state_next = S_READ;
                        end
                    end
                    else
                    begin
                        state_next = S_OUT;
                    end
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (cmp.tag_hit && !flush_reg)
                begin
                    state_next = S_OUT;
                end
                else if (last_slot)
                begin
                    state_next = flush_reg ? S_OUT : S_DECIDE;
                end
                else
                begin
                    state_next = S_READ;
                end
            end
            S_DECIDE:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (rsp_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Cache bookkeeping: slot count, end of used space and use clock.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slots_reg     <= '0;
            end_used_reg  <= '0;
            use_clock_reg <= '0;
        end
        else if (req_take)
        begin
            if (req.func == FN_FLUSH_ALL)
            begin
                slots_reg     <= '0;
                end_used_reg  <= '0;
                use_clock_reg <= '0;
            end
            else if ((req.func == FN_LOOKUP) && (req.remote_addr >= PASS_LIMIT))
            begin
                use_clock_reg <= use_clock_reg + USE_W'(1);
            end
        end
        else if ((state_reg == S_DECIDE) && !too_large && !empty_found_reg)
        begin
            if (append_fit)
            begin
                slots_reg    <= slots_reg + CNT_W'(1);
                end_used_reg <= end_used_reg + bytes_reg;
            end
            else if (!best_found_reg)
            begin
                slots_reg     <= CNT_W'(1);
                end_used_reg  <= bytes_reg;
                use_clock_reg <= '0;
            end
        end
    end

    // Item capture, scan index and search candidates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg         <= '0;
            flush_reg       <= 1'b0;
            empty_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if (req_take)
        begin
            idx_reg         <= '0;
            flush_reg       <= (req.func == FN_FLUSH_ONE);
            empty_found_reg <= 1'b0;
            best_found_reg  <= 1'b0;
        end
        else if ((state_reg == S_CHECK) && !flush_reg)
        begin
            if (cmp.is_empty && cmp.fits && !empty_found_reg)
            begin
                empty_found_reg <= 1'b1;
            end
            if (cmp.fits && cmp.older)
            begin
                best_found_reg <= 1'b1;
            end
            idx_reg <= idx_reg + IDX_W'(1);
        end
        else if (state_reg == S_CHECK)
        begin
            idx_reg <= idx_reg + IDX_W'(1);
        end
    end

    // Payload side of the capture and candidates.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            addr_reg     <= req.remote_addr;
            bytes_reg    <= req.item_bytes;
            best_use_reg <= LRU_CEILING;
        end
        else if ((state_reg == S_CHECK) && !flush_reg)
        begin
            if (cmp.is_empty && cmp.fits && !empty_found_reg)
            begin
                empty_idx_reg    <= idx_reg;
                empty_bucket_reg <= rd_entry.bucket;
                empty_base_reg   <= rd_entry.base;
            end
            if (cmp.fits && cmp.older)
            begin
                best_idx_reg    <= idx_reg;
                best_use_reg    <= rd_entry.last_use;
                best_bucket_reg <= rd_entry.bucket;
                best_base_reg   <= rd_entry.base;
            end
        end
    end

    // Result assembly.
    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            res_reg.status     <= ST_FLUSH_DONE;
            res_reg.slot       <= '0;
            res_reg.local_addr <= '0;
            if ((req.func == FN_LOOKUP) && (req.remote_addr < PASS_LIMIT))
            begin
                res_reg.status     <= ST_PASS;
                res_reg.local_addr <= req.remote_addr;
            end
        end
        else if ((state_reg == S_CHECK) && cmp.tag_hit && !flush_reg)
        begin
            res_reg.status     <= ST_HIT;
            res_reg.slot       <= SLOT_W'(idx_reg);
            res_reg.local_addr <= ADDR_W'(rd_entry.base);
        end
        else if (state_reg == S_DECIDE)
        begin
            if (too_large)
            begin
                res_reg.status     <= ST_TOO_LARGE;
                res_reg.slot       <= '0;
                res_reg.local_addr <= '0;
            end
            else if (empty_found_reg)
            begin
                res_reg.status     <= ST_REUSED;
                res_reg.slot       <= SLOT_W'(empty_idx_reg);
                res_reg.local_addr <= ADDR_W'(empty_base_reg);
            end
            else if (append_fit)
            begin
                res_reg.status     <= ST_APPENDED;
                res_reg.slot       <= SLOT_W'(slots_reg);
                res_reg.local_addr <= ADDR_W'(end_used_reg);
            end
            else if (best_found_reg)
            begin
                res_reg.status     <= ST_REPLACED;
                res_reg.slot       <= SLOT_W'(best_idx_reg);
                res_reg.local_addr <= ADDR_W'(best_base_reg);
            end
            else
            begin
                res_reg.status     <= ST_FLUSH_APPEND;
                res_reg.slot       <= '0;
                res_reg.local_addr <= '0;
            end
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if ((state_reg == S_OUT) && rsp_free)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_OUT) && rsp_free)
        begin
            rsp_reg <= res_reg;
        end
    end

    // The slot count never exceeds the number of slots.
    a_slot_count: assert property (@(posedge clk) disable iff (!rst_n)
        slots_reg <= SLOT_COUNT)
        else $error("slot count above capacity");

    // An empty cache has no used space.
    a_empty_end: assert property (@(posedge clk) disable iff (!rst_n)
        (slots_reg == '0) |-> (end_used_reg == '0))
        else $error("used space without slots");

    // The scan only reads allocated slots.
    a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (CNT_W'(idx_reg) < slots_reg))
        else $error("scan beyond allocated slots");

    // Leaving the output state always presents a result.
    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_OUT) && rsp_free) |=> rsp_valid_reg)
        else $error("result lost on output");

endmodule

/* tb/vslc_slot_tracker.sv */
// ----------------------------------------------------------------------------
// Object cache slot tracker
// Watches the request, result and register ports of the object cache, keeps
// its own copy of the slot table and use clock, predicts the result of every
// accepted item and compares it field by field with the result that comes out.
// ----------------------------------------------------------------------------
module vslc_slot_tracker
    import vslc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  req_item_t   req,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  rsp_item_t   rsp,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          bad_results,
    output int          items_in_flight
);

    localparam int SLOTS = VSLC_SLOTS;
    // Byte address of the store size register.
    localparam logic [2:0] STORE_ADDR = {REG_STORE_BYTES, 2'b00};
    // Mismatch reports stop after this many bad results.
    localparam int REPORT_CAP = 100;

    // Shadow copy of the cache state.
    logic [BYTES_W-1:0] store_bytes;
    logic [ADDR_W-1:0]  tag_mem [SLOTS];
    logic [BYTES_W-1:0] bucket_mem [SLOTS];
    logic [BYTES_W-1:0] base_mem [SLOTS];
    logic [USE_W-1:0]   last_use_mem [SLOTS];
    int                 slots_used;
    logic [USE_W-1:0]   use_clock;

    // Results still owed by the cache, oldest first.
    rsp_item_t          owed_results[$];
    int                 mismatches;

    function automatic rsp_item_t answer(logic [STAT_W-1:0] status, int slot,
                                         logic [ADDR_W-1:0] local_addr);
        rsp_item_t r;
        r.status     = status;
        r.slot       = slot[SLOT_W-1:0];
        r.local_addr = local_addr;
        return r;
    endfunction

    function automatic void clear_slots();
        for (int i = 0; i < SLOTS; i++)
        begin
            tag_mem[i]      = '0;
            bucket_mem[i]   = '0;
            base_mem[i]     = '0;
            last_use_mem[i] = '0;
        end
        slots_used = 0;
        use_clock  = '0;
    endfunction

    // End of the last allocated bucket, kept wider than the store size.
    function automatic logic [31:0] bucket_end();
        if (slots_used == 0)
            return 32'd0;
        return 32'(base_mem[slots_used-1]) + 32'(bucket_mem[slots_used-1]);
    endfunction

    function automatic int append_slot(logic [ADDR_W-1:0] addr, logic [BYTES_W-1:0] bytes);
        logic [31:0] tail;
        int n;
        tail = bucket_end();
        n = slots_used;
        tag_mem[n]      = addr;
        bucket_mem[n]   = bytes;
        base_mem[n]     = tail[BYTES_W-1:0];
        last_use_mem[n] = use_clock;
        slots_used      = n + 1;
        return n;
    endfunction

    // Lookup of a cacheable address: hit, then the placement order of a miss.
    function automatic rsp_item_t place_object(logic [ADDR_W-1:0] addr,
                                               logic [BYTES_W-1:0] bytes);
        logic [31:0] used;
        logic [31:0] room;
        logic [USE_W-1:0] oldest;
        int pick;
        int n;
        use_clock = use_clock + 1;
        for (int i = 0; i < slots_used; i++)
        begin
            if (tag_mem[i] == addr)
            begin
                last_use_mem[i] = use_clock;
                return answer(ST_HIT, i, 32'(base_mem[i]));
            end
        end
        if (bytes > store_bytes)
            return answer(ST_TOO_LARGE, 0, '0);
        // First empty slot whose bucket is big enough.
        for (int i = 0; i < slots_used; i++)
        begin
            if (tag_mem[i] == '0 && bucket_mem[i] >= bytes)
            begin
                tag_mem[i]      = addr;
                last_use_mem[i] = use_clock;
                return answer(ST_REUSED, i, 32'(base_mem[i]));
            end
        end
        // A new slot at the end of the used part of the store.
        used = bucket_end();
        room = (32'(store_bytes) > used) ? 32'(store_bytes) - used : 32'd0;
        if (slots_used < SLOTS && 32'(bytes) <= room)
        begin
            n = append_slot(addr, bytes);
            return answer(ST_APPENDED, n, 32'(base_mem[n]));
        end
        // Least recently used slot that fits, first one on ties.
        pick = -1;
        oldest = LRU_CEILING;
        for (int i = 0; i < slots_used; i++)
        begin
            if (bucket_mem[i] >= bytes && last_use_mem[i] < oldest)
            begin
                pick   = i;
                oldest = last_use_mem[i];
            end
        end
        if (pick >= 0)
        begin
            tag_mem[pick]      = addr;
            last_use_mem[pick] = use_clock;
            return answer(ST_REPLACED, pick, 32'(base_mem[pick]));
        end
        // Nothing fits: start over from an empty store.
        clear_slots();
        n = append_slot(addr, bytes);
        return answer(ST_FLUSH_APPEND, n, 32'(base_mem[n]));
    endfunction

    function automatic rsp_item_t predict_result(req_item_t it);
        case (it.func)
            FN_LOOKUP:
            begin
                if (it.remote_addr < PASS_LIMIT)
                    return answer(ST_PASS, 0, it.remote_addr);
                return place_object(it.remote_addr, it.item_bytes);
            end
            FN_FLUSH_ONE:
            begin
                for (int i = 0; i < slots_used; i++)
                begin
                    if (tag_mem[i] == it.remote_addr)
                    begin
                        tag_mem[i]      = '0;
                        last_use_mem[i] = '0;
                    end
                end
            end
            FN_FLUSH_ALL:
                clear_slots();
            default:
                ;
        endcase
        return answer(ST_FLUSH_DONE, 0, '0);
    endfunction

    // Register writes, result checks and predictions, all at the clock edge.
    always @(posedge clk or negedge rst_n)
    begin : track
        rsp_item_t want;
        bit bad;
        if (!rst_n)
        begin
            store_bytes = STORE_RESET;
            clear_slots();
            owed_results.delete();
            mismatches = 0;
            bad_results <= 0;
            items_in_flight <= 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == STORE_ADDR)
                store_bytes = pwdata[BYTES_W-1:0];

            // Check the result first so that an item taken in the same cycle
            // cannot stand in for a missing expectation.
            if (rsp_valid && !rsp_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    if (mismatches < REPORT_CAP)
                        $error("unexpected result: status %0d slot %0d local_addr %h",
                               rsp.status, rsp.slot, rsp.local_addr);
                    mismatches++;
                end
                else
                begin
                    want = owed_results.pop_front();
                    bad = 1'b0;
                    if (rsp.status !== want.status)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_CAP)
                            $error("status: expected %0d, got %0d", want.status, rsp.status);
                    end
                    if (rsp.slot !== want.slot)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_CAP)
                            $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
                    end
                    if (rsp.local_addr !== want.local_addr)
                    begin
                        bad = 1'b1;
                        if (mismatches < REPORT_CAP)
                            $error("local_addr: expected %h, got %h",
                                   want.local_addr, rsp.local_addr);
                    end
                    if (bad)
                        mismatches++;
                end
            end

            if (req_valid && !req_stall)
                owed_results.push_back(predict_result(req));

            bad_results <= mismatches;
            items_in_flight <= owed_results.size();
        end
    end

endmodule

/* tb/variable_slot_lru_object_cache_test.sv */
// ----------------------------------------------------------------------------
// Object cache regression
// Drives directed and random lookups and flushes into the object cache under
// several store sizes, with bursty requests and a stalling result side, and
// reports the verdict from the slot tracker's count of bad results.
// ----------------------------------------------------------------------------
module variable_slot_lru_object_cache_test;
    import vslc_pkg::*;

    localparam int  STALL_LIMIT   = 3000;
    localparam int  HOLD_CYCLES   = 500;
    localparam int  HOLD_AFTER    = 400;
    localparam int  DRAIN_CYCLES  = 60;
    localparam int  PHASE_ITEMS   = 154;
    localparam int  POOL_MAX      = 32;
    localparam int  STORE_MAX     = 262144;
    localparam logic [2:0] STORE_ADDR = {REG_STORE_BYTES, 2'b00};

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_stall;
    req_item_t   req       = '0;
    logic        rsp_valid;
    logic        rsp_stall = 1'b0;
    rsp_item_t   rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int          bad_results;
    int          items_in_flight;

    // Stimulus shaping: the store size in force and the addresses in play.
    int               store_now = STORE_RESET;
    logic [31:0]      tag_pool [POOL_MAX];
    int               pool_size = 1;
    int               idle_cycles = 0;

    variable_slot_lru_object_cache i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    vslc_slot_tracker i_tracker (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .bad_results     (bad_results),
        .items_in_flight (items_in_flight)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Result side: segments of random stall density, and one long hold-off
    // once enough results have gone by and the sender is offering, so that
    // the cache backs up.
    initial
    begin : result_side
        int taken;
        int segment;
        int percent;
        bit held;
        taken = 0;
        held = 1'b0;
        forever
        begin
            segment = $urandom_range(10, 150);
            case ($urandom_range(0, 4))
                0, 1: percent = 0;
                2: percent = 30;
                3: percent = 60;
                default: percent = 90;
            endcase
            repeat (segment)
            begin
                @(posedge clk);
                if (rsp_valid && !rsp_stall)
                    taken++;
                if (!held && taken >= HOLD_AFTER && req_valid)
                begin
                    held = 1'b1;
                    rsp_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                else
                    rsp_stall <= ($urandom_range(1, 100) <= percent);
            end
        end
    end

    // Watchdog: ends the run when nothing moves for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic req_item_t make_item(logic [FUNC_W-1:0] fn, logic [ADDR_W-1:0] addr,
                                            int bytes);
        req_item_t it;
        it.func        = fn;
        it.remote_addr = addr;
        it.item_bytes  = bytes[BYTES_W-1:0];
        return it;
    endfunction

    // Offer one item and hold it until the cache takes it.
    task automatic send_item(req_item_t it);
        req       <= it;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // Stop offering and wait until every owed result has come back.
    task automatic wait_drained();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (items_in_flight != 0);
    endtask

    // Set the store size while the cache is idle.
    task automatic write_store(int bytes);
        wait_drained();
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= STORE_ADDR;
        pwdata  <= 32'(bytes);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        store_now = bytes;
    endtask

    function automatic void refill_pool();
        pool_size = $urandom_range(4, POOL_MAX - 2);
        for (int i = 0; i < POOL_MAX; i++)
        begin
            tag_pool[i] = $urandom;
            if (tag_pool[i] < PASS_LIMIT)
                tag_pool[i] = tag_pool[i] | PASS_LIMIT;
        end
    endfunction

    // Object sizes: mostly small next to the store, with exact fits,
    // oversize objects, zero bytes and anything at all mixed in.
    function automatic int pick_bytes();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return 0;
        if (r < 14)
            return store_now;
        if (r < 24)
            return (store_now < STORE_MAX) ? $urandom_range(store_now + 1, STORE_MAX)
                                           : STORE_MAX;
        if (r < 32)
            return $urandom_range(0, STORE_MAX);
        return $urandom_range(0, store_now / $urandom_range(4, 24));
    endfunction

    function automatic req_item_t random_item();
        int r;
        logic [ADDR_W-1:0] addr;
        r = $urandom_range(0, 99);
        if (r < 84)
        begin
            if ($urandom_range(0, 99) < 12)
                addr = $urandom_range(0, PASS_LIMIT - 1);
            else
                addr = tag_pool[$urandom_range(0, pool_size - 1)];
            return make_item(FN_LOOKUP, addr, pick_bytes());
        end
        if (r < 94)
        begin
            case ($urandom_range(0, 9))
                0: addr = '0;
                1: addr = $urandom;
                default: addr = tag_pool[$urandom_range(0, pool_size - 1)];
            endcase
            return make_item(FN_FLUSH_ONE, addr, $urandom_range(0, STORE_MAX));
        end
        if (r < 97)
            return make_item(FN_FLUSH_ALL, $urandom, $urandom_range(0, STORE_MAX));
        return make_item(FN_UNUSED, $urandom, $urandom_range(0, STORE_MAX));
    endfunction

    initial
    begin : stimulus
        int store_plan [8];
        int burst_left;
        store_plan = '{65536, 4096, STORE_MAX, 0, 100000, 1, STORE_MAX, 20000};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset store size: passthrough edges, append,
        // hit, flush then append, oversize, zero-byte append at a full store,
        // flush one including address zero, reuse of an empty slot, the
        // unused code and flush all.
        send_item(make_item(FN_LOOKUP, 32'h0000_0000, 0));
        send_item(make_item(FN_LOOKUP, PASS_LIMIT - 1, 19'h7ffff));
        send_item(make_item(FN_LOOKUP, PASS_LIMIT, 1000));
        send_item(make_item(FN_LOOKUP, PASS_LIMIT, 0));
        send_item(make_item(FN_LOOKUP, 32'hffff_ffff, 65536));
        send_item(make_item(FN_LOOKUP, 32'h8000_0000, 65537));
        send_item(make_item(FN_LOOKUP, 32'h1234_5678, 0));
        send_item(make_item(FN_FLUSH_ONE, 32'hffff_ffff, 0));
        send_item(make_item(FN_LOOKUP, 32'h0004_0001, 100));
        send_item(make_item(FN_FLUSH_ONE, 32'h0000_0000, 0));
        send_item(make_item(FN_UNUSED, 32'h1234_5678, 5));
        send_item(make_item(FN_LOOKUP, 32'hdead_beef, STORE_MAX));
        send_item(make_item(FN_FLUSH_ALL, 32'h5555_aaaa, 0));

        // Full-size store: a bucket of the whole store, then a zero-byte
        // object whose base sits at the very end, then an LRU replacement.
        write_store(STORE_MAX);
        send_item(make_item(FN_LOOKUP, 32'h4000_0000, STORE_MAX));
        send_item(make_item(FN_LOOKUP, 32'h4000_0001, 0));
        send_item(make_item(FN_LOOKUP, 32'h4000_0002, 1));
        send_item(make_item(FN_LOOKUP, 32'h4000_0001, 7));

        // Store shrunk below the used end: no free space left.
        write_store(0);
        send_item(make_item(FN_LOOKUP, 32'h5000_0000, 0));
        send_item(make_item(FN_LOOKUP, 32'h5000_0004, 1));
        send_item(make_item(FN_LOOKUP, 32'h4000_0002, 3));

        // Random part: one phase per store size, bursts with gaps between
        // them, and now and then a pause until every result is back.
        burst_left = 0;
        for (int p = 0; p < 8; p++)
        begin
            write_store(store_plan[p]);
            refill_pool();
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(random_item());
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 15) == 0)
                        wait_drained();
                    else if ($urandom_range(0, 3) != 0)
                    begin
                        req_valid <= 1'b0;
                        repeat ($urandom_range(1, 20)) @(posedge clk);
                    end
                end
                else
                    burst_left--;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (bad_results == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
